[sv/pwvr_pkg.sv]
// ----------------------------------------------------------------------------
// pwvr_pkg: shared types and constants for the pulse-wait voltage regulator
// holds field widths, codes, register indexes and the structs between modules
// ----------------------------------------------------------------------------
package pwvr_pkg;

  localparam int unsigned PWVR_TIMER_BITS = 17;

  localparam int unsigned VOLT_W  = 12;  // readings in tenths of a volt
  localparam int unsigned PULSE_W = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [PULSE_W-1:0] CENTER_US = 11'd1500;

  typedef enum logic [0:0] {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ACTIVE = 2'd1,
    MODE_UNDER  = 2'd2,
    MODE_OVER   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SETTLE = 2'd1,
    PH_PULSE  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET      = 3'd0,
    CFG_TOLERANCE   = 3'd1,
    CFG_MIN_INPUT   = 3'd2,
    CFG_SETTLE      = 3'd3,
    CFG_PULSE       = 3'd4,
    CFG_STALL       = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  target_voltage;
    logic [6:0]  tolerance;
    logic [8:0]  min_input_voltage;
    logic [15:0] settle_ticks;
    logic [15:0] pulse_ticks;
    logic [15:0] stall_ticks;
  } pwvr_cfg_t;

  typedef struct packed {
    logic              op;
    logic [VOLT_W-1:0] vin_tenths;
    logic [VOLT_W-1:0] vout_tenths;
  } pwvr_item_t;

  typedef struct packed {
    logic               servo_enable;
    logic [PULSE_W-1:0] servo_pulse_us;
    logic [1:0]         reg_status;
    logic [1:0]         servo_phase;
    logic               alarm_raised;
  } pwvr_result_t;

endpackage

[sv/pwvr_if.sv]
// ----------------------------------------------------------------------------
// pwvr channel interfaces
// valid/ready channels for the input items and the result items
// ----------------------------------------------------------------------------
interface pwvr_in_if;
  import pwvr_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [VOLT_W-1:0] vin_tenths;
  logic [VOLT_W-1:0] vout_tenths;

  modport source (output valid, output op, output vin_tenths, output vout_tenths,
                  input ready);
  modport sink   (input valid, input op, input vin_tenths, input vout_tenths,
                  output ready);
endinterface

interface pwvr_out_if;
  import pwvr_pkg::*;

  logic               valid;
  logic               ready;
  logic               servo_enable;
  logic [PULSE_W-1:0] servo_pulse_us;
  logic [1:0]         reg_status;
  logic [1:0]         servo_phase;
  logic               alarm_raised;

  modport source (output valid, output servo_enable, output servo_pulse_us,
                  output reg_status, output servo_phase, output alarm_raised,
                  input ready);
  modport sink   (input valid, input servo_enable, input servo_pulse_us,
                  input reg_status, input servo_phase, input alarm_raised,
                  output ready);
endinterface

[sv/pulse_wait_voltage_regulator_unit.sv]
// an accepted input transaction passes the input register, then the result register
// throughput: one transaction per cycle; the input register and the result
//   register each hand over whenever the next stage is free or drains
// reset (rst_ni low, asynchronous): mode and phase idle, timers and stored
//   output cleared, direction none, drive 1500 us, registers at defaults
// ----------------------------------------------------------------------------
// pulse_wait_voltage_regulator_unit: servo variac regulator top level
// pulse-and-wait deadband regulation with three-speed correction pulses,
// stall alarms and recovery checks, one result per input transaction
// ----------------------------------------------------------------------------
module pulse_wait_voltage_regulator_unit #(
  parameter int unsigned TIMER_BITS = pwvr_pkg::PWVR_TIMER_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [pwvr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pwvr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // transaction channels
  pwvr_in_if.sink                         in_i,
  pwvr_out_if.source                      out_o
);
  import pwvr_pkg::*;

  pwvr_cfg_t    cfg;
  pwvr_item_t   item_q;
  logic         item_valid_q;
  pwvr_result_t res;
  pwvr_result_t res_q;
  logic         res_valid_q;

  // handshake plumbing
  logic in_fire;    // input transaction lands in the input register
  logic step_fire;  // input register retires into the result register

  // the input register moves on when the result register is empty or
  // is being emptied this cycle; the input side refills behind it
  assign step_fire = item_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !item_valid_q || step_fire;
  assign in_fire   = in_i.valid && in_i.ready;

  pwvr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register: valid is control, payload only loads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.op          <= in_i.op;
      item_q.vin_tenths  <= in_i.vin_tenths;
      item_q.vout_tenths <= in_i.vout_tenths;
    end
  end

  // regulator state commits on the same edge the result is captured
  pwvr_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step_fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step_fire) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      res_q <= res;
    end
  end

  assign out_o.valid          = res_valid_q;
  assign out_o.servo_enable   = res_q.servo_enable;
  assign out_o.servo_pulse_us = res_q.servo_pulse_us;
  assign out_o.reg_status     = res_q.reg_status;
  assign out_o.servo_phase    = res_q.servo_phase;
  assign out_o.alarm_raised   = res_q.alarm_raised;

endmodule

[sv/pwvr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pwvr_cfg_regs: configuration register bank
// decodes the write port into the six regulator settings
// ----------------------------------------------------------------------------
module pwvr_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pwvr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pwvr_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output pwvr_pkg::pwvr_cfg_t                 cfg_o
);
  import pwvr_pkg::*;

  pwvr_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_TARGET:    cfg_d.target_voltage    = cfg_wdata_i[7:0];
        CFG_TOLERANCE: cfg_d.tolerance         = cfg_wdata_i[6:0];
        CFG_MIN_INPUT: cfg_d.min_input_voltage = cfg_wdata_i[8:0];
        CFG_SETTLE:    cfg_d.settle_ticks      = cfg_wdata_i;
        CFG_PULSE:     cfg_d.pulse_ticks       = cfg_wdata_i;
        CFG_STALL:     cfg_d.stall_ticks       = cfg_wdata_i;
        default:       cfg_d = cfg_q;  // unused index, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_voltage    <= 8'd0;
      cfg_q.tolerance         <= 7'd2;
      cfg_q.min_input_voltage <= 9'd50;
      cfg_q.settle_ticks      <= 16'd1000;
      cfg_q.pulse_ticks       <= 16'd100;
      cfg_q.stall_ticks       <= 16'd5000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/pwvr_step.sv]
// ----------------------------------------------------------------------------
// pwvr_step: regulator state and per-transaction update rule
// holds mode, phase, timers and drive state; computes the next result
// ----------------------------------------------------------------------------
module pwvr_step #(
  parameter int unsigned TIMER_BITS = pwvr_pkg::PWVR_TIMER_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  pwvr_pkg::pwvr_item_t  item_i,
  input  pwvr_pkg::pwvr_cfg_t   cfg_i,
  output pwvr_pkg::pwvr_result_t res_o
);
  import pwvr_pkg::*;

  localparam int unsigned CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  mode_e               mode_q, mode_d;
  phase_e              phase_q, phase_d;
  dir_e                dir_q, dir_d;
  logic [TIMER_BITS-1:0] pt_q, pt_d, pt_inc;
  logic [TIMER_BITS-1:0] st_q, st_d, st_inc;
  logic [VOLT_W-1:0]   last_q, last_d;
  logic [PULSE_W-1:0]  drive_q, drive_d;
  logic                raised;

  logic [24:0]         vout_prod;
  logic [8:0]          vout_volts;
  logic signed [9:0]   err;
  logic [8:0]          mag;
  logic [12:0]         min_x10;
  logic                low_input;
  logic [7:0]          speed;
  logic [VOLT_W-1:0]   out_diff;
  logic [16:0]         vin_x25;
  logic [16:0]         tgt_x220;
  logic [12:0]         over_lim;
  logic                settle_done, pulse_done;

  // whole volts by reciprocal multiply, exact for 12-bit readings
  assign vout_prod  = 25'(item_i.vout_tenths) * 25'd6554;
  assign vout_volts = vout_prod[24:16];
  assign err        = $signed({2'b00, cfg_i.target_voltage}) - $signed({1'b0, vout_volts});
  assign mag        = err[9] ? 9'(-err) : err[8:0];

  assign min_x10    = 13'(cfg_i.min_input_voltage) * 13'd10;
  assign low_input  = 13'(item_i.vin_tenths) < min_x10;

  assign out_diff   = (item_i.vout_tenths > last_q) ? item_i.vout_tenths - last_q
                                                    : last_q - item_i.vout_tenths;

  assign vin_x25    = 17'(item_i.vin_tenths) * 17'd25;
  assign tgt_x220   = 17'(cfg_i.target_voltage) * 17'd220;
  assign over_lim   = (13'(cfg_i.target_voltage) + 13'(cfg_i.tolerance)) * 13'd10;

  assign pt_inc = (pt_q == '1) ? pt_q : pt_q + 1'b1;
  assign st_inc = (st_q == '1) ? st_q : st_q + 1'b1;

  assign settle_done = CMP_W'(pt_inc) >= CMP_W'(cfg_i.settle_ticks);
  assign pulse_done  = CMP_W'(pt_inc) >= CMP_W'(cfg_i.pulse_ticks);

  always_comb begin
    if (mag > 9'd30)      speed = 8'd200;
    else if (mag > 9'd10) speed = 8'd100;
    else                  speed = 8'd50;
  end

  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    dir_d   = dir_q;
    pt_d    = pt_q;
    st_d    = st_q;
    last_d  = last_q;
    drive_d = drive_q;
    raised  = 1'b0;

    if (item_i.op == OP_START) begin
      mode_d  = MODE_ACTIVE;
      phase_d = PH_SETTLE;
      pt_d    = '0;
      st_d    = '0;
    end else begin
      pt_d = pt_inc;
      st_d = st_inc;
      unique case (mode_q)
        MODE_ACTIVE: begin
          if (low_input) begin
            phase_d = PH_IDLE;
          end else begin
            unique case (phase_q)
              PH_IDLE: begin
                if (mag > 9'(cfg_i.tolerance)) begin
                  phase_d = PH_SETTLE;
                  pt_d    = '0;
                end
              end
              PH_SETTLE: begin
                if (settle_done) begin
                  if (mag <= 9'(cfg_i.tolerance)) begin
                    phase_d = PH_IDLE;
                  end else begin
                    if (err > 0) begin
                      drive_d = CENTER_US + PULSE_W'(speed);
                      dir_d   = DIR_UP;
                    end else begin
                      drive_d = CENTER_US - PULSE_W'(speed);
                      dir_d   = DIR_DOWN;
                    end
                    phase_d = PH_PULSE;
                    pt_d    = '0;
                  end
                end
              end
              default: begin
                if (pulse_done) begin
                  phase_d = PH_SETTLE;
                  pt_d    = '0;
                end
              end
            endcase
          end
          // output movement and stall detection
          if (out_diff > 12'd10) begin
            last_d = item_i.vout_tenths;
            st_d   = '0;
          end
          if (phase_d != PH_IDLE && CMP_W'(st_d) > CMP_W'(cfg_i.stall_ticks)) begin
            phase_d = PH_IDLE;
            if (dir_d == DIR_UP) begin
              mode_d = MODE_UNDER;
              raised = 1'b1;
            end else if (dir_d == DIR_DOWN) begin
              mode_d = MODE_OVER;
              raised = 1'b1;
            end
          end
        end
        MODE_UNDER: begin
          if (vin_x25 >= tgt_x220) begin
            mode_d = MODE_ACTIVE;
            st_d   = '0;
          end
        end
        MODE_OVER: begin
          if (13'(item_i.vout_tenths) <= over_lim) begin
            mode_d = MODE_ACTIVE;
            st_d   = '0;
          end
        end
        default: mode_d = mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      phase_q <= PH_IDLE;
      dir_q   <= DIR_NONE;
      pt_q    <= '0;
      st_q    <= '0;
      last_q  <= '0;
      drive_q <= CENTER_US;
    end else if (en_i) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      dir_q   <= dir_d;
      pt_q    <= pt_d;
      st_q    <= st_d;
      last_q  <= last_d;
      drive_q <= drive_d;
    end
  end

  assign res_o.servo_enable   = (phase_d == PH_PULSE);
  assign res_o.servo_pulse_us = (phase_d == PH_PULSE) ? drive_d : CENTER_US;
  assign res_o.reg_status     = mode_d;
  assign res_o.servo_phase    = phase_d;
  assign res_o.alarm_raised   = raised;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the pulse-wait voltage regulator unit
// drives tick and start transactions through the input channel, predicts each
// servo command transaction and compares it field by field, over several
// register settings and idle patterns on both channels
// ----------------------------------------------------------------------------
module tb;
  import pwvr_pkg::*;

  localparam int unsigned RUN_LIMIT  = 400000;  // cycles before giving up
  localparam int unsigned LONG_HOLD  = 64;      // receiver hold-off, cycles
  localparam int unsigned NUM_PHASES = 9;

  // predicts the servo command for every accepted transaction and holds the
  // commands still to come out of the block
  class servo_cmd_scoreboard;
    logic [7:0]  target_v;
    logic [6:0]  tol_v;
    logic [8:0]  min_in_v;
    logic [15:0] settle_len;
    logic [15:0] pulse_len;
    logic [15:0] stall_len;

    mode_e                      mode;
    phase_e                     phase;
    logic [PWVR_TIMER_BITS-1:0] phase_cnt;
    logic [PWVR_TIMER_BITS-1:0] stall_cnt;
    logic [VOLT_W-1:0]          last_vout;
    dir_e                       dir;
    logic [PULSE_W-1:0]         drive_us;

    pwvr_result_t servo_cmd_q[$];
    int unsigned  mismatches;

    function new();
      target_v   = 8'd0;
      tol_v      = 7'd2;
      min_in_v   = 9'd50;
      settle_len = 16'd1000;
      pulse_len  = 16'd100;
      stall_len  = 16'd5000;
      mode       = MODE_IDLE;
      phase      = PH_IDLE;
      phase_cnt  = '0;
      stall_cnt  = '0;
      last_vout  = '0;
      dir        = DIR_NONE;
      drive_us   = CENTER_US;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_TARGET:    target_v   = val[7:0];
        CFG_TOLERANCE: tol_v      = val[6:0];
        CFG_MIN_INPUT: min_in_v   = val[8:0];
        CFG_SETTLE:    settle_len = val;
        CFG_PULSE:     pulse_len  = val;
        CFG_STALL:     stall_len  = val;
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return servo_cmd_q.size();
    endfunction

    function void note_reading(pwvr_item_t it);
      int           vin_i;
      int           vout_i;
      int           err;
      int           mag;
      int           speed;
      int           diff;
      logic         raised;
      pwvr_result_t want;

      vin_i  = int'(it.vin_tenths);
      vout_i = int'(it.vout_tenths);
      raised = 1'b0;

      if (it.op == OP_START) begin
        // start overrides everything, readings ignored
        mode      = MODE_ACTIVE;
        phase     = PH_SETTLE;
        phase_cnt = '0;
        stall_cnt = '0;
      end else begin
        if (phase_cnt != '1) phase_cnt++;
        if (stall_cnt != '1) stall_cnt++;

        if (mode == MODE_ACTIVE) begin
          if (vin_i < int'(min_in_v) * 10) begin
            phase = PH_IDLE;  // input too low, servo stopped
          end else begin
            err = int'(target_v) - vout_i / 10;
            mag = (err < 0) ? -err : err;
            case (phase)
              PH_IDLE: begin
                if (mag > int'(tol_v)) begin
                  phase     = PH_SETTLE;
                  phase_cnt = '0;
                end
              end
              PH_SETTLE: begin
                if (phase_cnt >= settle_len) begin
                  if (mag <= int'(tol_v)) begin
                    phase = PH_IDLE;
                  end else begin
                    speed = (mag > 30) ? 200 : ((mag > 10) ? 100 : 50);
                    if (err > 0) begin
                      drive_us = CENTER_US + PULSE_W'(speed);
                      dir      = DIR_UP;
                    end else begin
                      drive_us = CENTER_US - PULSE_W'(speed);
                      dir      = DIR_DOWN;
                    end
                    phase     = PH_PULSE;
                    phase_cnt = '0;
                  end
                end
              end
              default: begin
                if (phase_cnt >= pulse_len) begin
                  phase     = PH_SETTLE;
                  phase_cnt = '0;
                end
              end
            endcase
          end

          // output movement resets the stall watch
          diff = vout_i - int'(last_vout);
          if (diff < 0) diff = -diff;
          if (diff > 10) begin
            last_vout = it.vout_tenths;
            stall_cnt = '0;
          end
          if (phase != PH_IDLE && stall_cnt > stall_len) begin
            phase = PH_IDLE;
            if (dir == DIR_UP) begin
              mode   = MODE_UNDER;
              raised = 1'b1;
            end else if (dir == DIR_DOWN) begin
              mode   = MODE_OVER;
              raised = 1'b1;
            end
          end
        end else if (mode == MODE_UNDER) begin
          // input scaled by 250/220 reaches the target
          if (vin_i * 25 >= int'(target_v) * 220) begin
            mode      = MODE_ACTIVE;
            stall_cnt = '0;
          end
        end else if (mode == MODE_OVER) begin
          if (vout_i <= (int'(target_v) + int'(tol_v)) * 10) begin
            mode      = MODE_ACTIVE;
            stall_cnt = '0;
          end
        end
      end

      want.servo_enable   = (phase == PH_PULSE);
      want.servo_pulse_us = (phase == PH_PULSE) ? drive_us : CENTER_US;
      want.reg_status     = mode;
      want.servo_phase    = phase;
      want.alarm_raised   = raised;
      servo_cmd_q.push_back(want);
    endfunction

    function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s expected %0d got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_servo_cmd(pwvr_result_t got);
      pwvr_result_t want;
      if (servo_cmd_q.size() == 0) begin
        $error("servo command transaction with nothing expected: %p", got);
        mismatches++;
        return;
      end
      want = servo_cmd_q.pop_front();
      cmp_field("servo_enable", 16'(want.servo_enable), 16'(got.servo_enable));
      cmp_field("servo_pulse_us", 16'(want.servo_pulse_us), 16'(got.servo_pulse_us));
      cmp_field("reg_status", 16'(want.reg_status), 16'(got.reg_status));
      cmp_field("servo_phase", 16'(want.servo_phase), 16'(got.servo_phase));
      cmp_field("alarm_raised", 16'(want.alarm_raised), 16'(got.alarm_raised));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  pwvr_in_if  in_ch ();
  pwvr_out_if out_ch ();

  pulse_wait_voltage_regulator_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  servo_cmd_scoreboard sb = new();

  int unsigned src_idle_pct;    // chance of a sender gap per cycle
  int unsigned sink_stall_pct;  // chance of the receiver holding off per cycle
  bit          hold_req;        // asks the receiver for one long hold-off
  int unsigned cycle_cnt;
  int          vout_lvl;        // slowly moving output reading, tenths
  pwvr_cfg_t   cur_cfg;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog, ends a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("pulse_wait_voltage_regulator_unit verification failed");
      $finish;
    end
  end

  // receiver side: random back-pressure, plus a long counted hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sb.check_servo_cmd({out_ch.servo_enable, out_ch.servo_pulse_us,
                          out_ch.reg_status, out_ch.servo_phase,
                          out_ch.alarm_raised});
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    sb.set_reg(idx, val);
  endtask

  // all six registers, only called while the block is idle
  task automatic program_regs(pwvr_cfg_t c);
    cur_cfg = c;
    write_reg(CFG_TARGET, CFG_DATA_W'(c.target_voltage));
    write_reg(CFG_TOLERANCE, CFG_DATA_W'(c.tolerance));
    write_reg(CFG_MIN_INPUT, CFG_DATA_W'(c.min_input_voltage));
    write_reg(CFG_SETTLE, c.settle_ticks);
    write_reg(CFG_PULSE, c.pulse_ticks);
    write_reg(CFG_STALL, c.stall_ticks);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one input transaction, with random sender gaps ahead of it
  task automatic offer(pwvr_item_t it);
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid       <= 1'b1;
    in_ch.op          <= it.op;
    in_ch.vin_tenths  <= it.vin_tenths;
    in_ch.vout_tenths <= it.vout_tenths;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_reading(it);
  endtask

  // stop offering and wait for every pending command, then the pipe latency
  task automatic drain_results();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic pwvr_item_t reading(op_e op, int vin, int vout);
    pwvr_item_t it;
    it.op          = op;
    it.vin_tenths  = VOLT_W'(vin);
    it.vout_tenths = VOLT_W'(vout);
    return it;
  endfunction

  function automatic pwvr_cfg_t random_settings();
    pwvr_cfg_t c;
    c.target_voltage    = 8'($urandom_range(0, 250));
    c.tolerance         = 7'($urandom_range(1, 20));
    c.min_input_voltage = 9'($urandom_range(0, 300));
    c.settle_ticks      = 16'($urandom_range(0, 10));
    c.pulse_ticks       = 16'($urandom_range(0, 8));
    c.stall_ticks       = 16'($urandom_range(2, 40));
    return c;
  endfunction

  // mostly plausible tick streams: input above the minimum, output drifting
  // slowly or holding still so that stalls happen; a few starts, a few low
  // inputs and some fully random noise
  function automatic pwvr_item_t next_reading();
    pwvr_item_t it;
    int         r;
    int         vin_lo;
    int         mv;
    r      = $urandom_range(0, 99);
    vin_lo = int'(cur_cfg.min_input_voltage) * 10;
    if (vin_lo > 4095) vin_lo = 4095;
    if (r < 8) begin
      it.op          = 1'($urandom_range(0, 1));
      it.vin_tenths  = VOLT_W'($urandom);
      it.vout_tenths = VOLT_W'($urandom);
      return it;
    end
    mv = $urandom_range(0, 99);
    if (mv >= 85) begin
      vout_lvl = int'(cur_cfg.target_voltage) * 10 + $urandom_range(0, 1200) - 600;
    end else if (mv >= 55) begin
      vout_lvl = vout_lvl + $urandom_range(0, 30) - 15;
    end
    if (vout_lvl < 0) vout_lvl = 0;
    if (vout_lvl > 4095) vout_lvl = 4095;
    it.op          = (r < 11) ? OP_START : OP_TICK;
    it.vout_tenths = VOLT_W'(vout_lvl);
    if (r < 15) it.vin_tenths = VOLT_W'($urandom_range(0, vin_lo));
    else        it.vin_tenths = VOLT_W'($urandom_range(vin_lo, 4095));
    return it;
  endfunction

  initial begin
    int unsigned n_items;
    pwvr_cfg_t   c;

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_TARGET;
    cfg_wdata_i       = '0;
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_TICK;
    in_ch.vin_tenths  = '0;
    in_ch.vout_tenths = '0;
    src_idle_pct      = 0;
    sink_stall_pct    = 0;
    hold_req          = 1'b0;
    cycle_cnt         = 0;
    vout_lvl          = 0;
    cur_cfg           = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // idle pattern rotates: none, sender gaps, receiver stalls, both
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 51; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 51; end
        default: begin src_idle_pct = 36; sink_stall_pct = 36; end
      endcase

      if (ph == 0) begin
        c = '{target_voltage: 8'd220, tolerance: 7'd2, min_input_voltage: 9'd50,
              settle_ticks: 16'd1, pulse_ticks: 16'd1, stall_ticks: 16'd4};
      end else if (ph == 3) begin
        c = '0;  // every register at its floor
      end else if (ph == 6) begin
        c = '1;  // every register at its ceiling
      end else begin
        c = random_settings();
      end
      program_regs(c);
      vout_lvl = int'(c.target_voltage) * 10;

      if (ph == 0) begin
        // ticks while idle do nothing, field extremes
        offer(reading(OP_TICK, 0, 0));
        offer(reading(OP_TICK, 4095, 4095));
        offer(reading(OP_START, 4095, 4095));
        // output far below target, never moves: pulses up then under-voltage
        repeat (6) offer(reading(OP_TICK, 2300, 1500));
        offer(reading(OP_TICK, 1000, 1500));  // input still too weak
        offer(reading(OP_TICK, 2300, 1500));  // recovers
        // output far above target, stuck: pulses down then over-voltage
        repeat (6) offer(reading(OP_TICK, 2300, 3000));
        offer(reading(OP_TICK, 2300, 3000));  // still too high
        offer(reading(OP_TICK, 2300, 2220));  // at target plus tolerance
        // input just below the minimum stops the servo
        offer(reading(OP_TICK, 499, 1500));
      end else begin
        n_items = (ph == 6) ? 60 : 253;
        for (int n = 0; n < n_items; n++) begin
          offer(next_reading());
          if (ph == 4 && n == 40) hold_req = 1'b1;  // block fills and stalls input
          if (ph == 2 && n == 100) drain_results();
        end
      end
      drain_results();
    end

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("pulse_wait_voltage_regulator_unit verification clean");
    end else begin
      $display("pulse_wait_voltage_regulator_unit verification failed");
    end
    $finish;
  end

endmodule
